// ===== hw/rtl/status_led_pattern_generator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Status LED pattern generator: assertion macros
// Shared concurrent assertion forms, clocked on clk_i; SLPG_ASSERT is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef STATUS_LED_PATTERN_GENERATOR_UNIT_ASSERT_SVH
`define STATUS_LED_PATTERN_GENERATOR_UNIT_ASSERT_SVH

// checked only outside reset
`define SLPG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("slpg: assertion failed");

// checked at every edge, reset included
`define SLPG_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("slpg: assertion failed");

`endif

// ===== hw/rtl/slpg_pkg.sv =====
// ----------------------------------------------------------------------------
// Status LED pattern generator package
// Types, operation and register codes, colours and timing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package slpg_pkg;

  typedef logic [23:0] rgb_t;

  typedef enum logic [2:0] {
    OP_TICK         = 3'd0,
    OP_SET_MODE     = 3'd1,
    OP_KEY_FLASH    = 3'd2,
    OP_LAYER_COLOUR = 3'd3,
    OP_WIFI_SLEEP   = 3'd4,
    OP_LOW_BATTERY  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    CFG_STEADY_LEVEL   = 2'd0,
    CFG_PULSE_LEVEL    = 2'd1,
    CFG_KEY_FLASH_MS   = 2'd2,
    CFG_LAYER_FLASH_MS = 2'd3
  } cfg_idx_e;

  // mode codes; 5..7 mean off
  localparam logic [2:0] MODE_WAITING   = 3'd0;
  localparam logic [2:0] MODE_CONNECTED = 3'd1;
  localparam logic [2:0] MODE_MIC       = 3'd2;
  localparam logic [2:0] MODE_HID_KEY   = 3'd3;
  localparam logic [2:0] MODE_VOICE_KEY = 3'd4;

  localparam rgb_t COLOUR_WHITE_DIM  = 24'h0C0C0C;
  localparam rgb_t COLOUR_RED_DIM    = 24'h0C0000;
  localparam rgb_t COLOUR_RED_FAINT  = 24'h020000;
  localparam rgb_t COLOUR_BLUE_DIM   = 24'h00000C;
  localparam rgb_t COLOUR_YELLOW_DIM = 24'h0C0C00;
  localparam rgb_t COLOUR_GREEN      = 24'h00FF00;
  localparam rgb_t COLOUR_OFF        = 24'h000000;

  localparam logic [7:0] STEADY_LEVEL_RST   = 8'd6;
  localparam logic [7:0] PULSE_LEVEL_RST    = 8'd12;
  localparam logic [7:0] KEY_FLASH_MS_RST   = 8'd100;
  localparam logic [7:0] LAYER_FLASH_MS_RST = 8'd200;

  // phase counters: 2 s and 4 s at 1 ms ticks
  localparam logic [10:0] PHASE_TWO_LAST  = 11'd1999;
  localparam logic [11:0] PHASE_FOUR_LAST = 12'd3999;

  // low-battery double pulse windows and heartbeat on-time
  localparam logic [10:0] PULSE_ONE_END   = 11'd120;
  localparam logic [10:0] PULSE_TWO_START = 11'd220;
  localparam logic [10:0] PULSE_TWO_END   = 11'd340;
  localparam logic [11:0] HEARTBEAT_ON    = 12'd150;

endpackage

`default_nettype wire

// ===== hw/rtl/slpg_dim.sv =====
// ----------------------------------------------------------------------------
// Colour dimmer
// Scales each channel of an RGB colour as c*level/255, truncating.
// ----------------------------------------------------------------------------
`default_nettype none

module slpg_dim
  import slpg_pkg::*;
(
  input  rgb_t       colour_i,
  input  logic [7:0] level_i,
  output rgb_t       colour_o
);

  // x/255 for x <= 255*255 is (x + (x >> 8) + 1) >> 8; the sum stays below 2^16
  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    logic [15:0] prod;
    logic [15:0] sum;

    assign prod = colour_i[8*ch +: 8] * level_i;
    assign sum  = prod + {8'd0, prod[15:8]} + 16'd1;
    assign colour_o[8*ch +: 8] = sum[15:8];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/status_led_pattern_generator_unit.sv =====
// ----------------------------------------------------------------------------
// Status LED pattern generator
// Picks the status LED colour from events and millisecond ticks.
// ----------------------------------------------------------------------------
// Each item (tick or event) is taken into an input register and evaluated
// as it leaves that register, when the state is updated and a colour, if it
// differs from the last one sent, is loaded into the result register. One item
// is accepted per cycle while the input register can drain. The only throttle
// is the result register: while it holds an unaccepted result, the input
// register cannot drain, so in_stall_o follows out_stall_i. Items that
// produce no result (flash arming, battery flag, ignored codes) leave the
// result channel untouched. Configuration writes take effect at once and are
// expected only while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module status_led_pattern_generator_unit
  import slpg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // item input
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] operation_i,
  input  logic [2:0] new_state_i,
  input  logic       voice_key_i,
  input  rgb_t       layer_rgb_i,
  input  logic       flag_value_i,
  // result output
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output rgb_t       led_rgb_o,
  // configuration writes
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_wdata_i
);

  // configuration
  logic [7:0] steady_level_q, pulse_level_q, key_flash_ms_q, layer_flash_ms_q;

  // input register
  logic       s1_valid_q;
  logic [2:0] op_q, ns_q;
  logic       vk_q, fv_q;
  rgb_t       rgb_q;

  // block state
  logic [2:0]  base_mode_q, base_mode_d;
  logic        flash_voice_q, flash_voice_d;
  logic        flash_act_q, flash_act_d;
  logic        layer_flash_q, layer_flash_d;
  logic [7:0]  flash_rem_q, flash_rem_d;
  rgb_t        layer_colour_q, layer_colour_d;
  logic        batt_low_q, batt_low_d;
  logic        wifi_sleep_q, wifi_sleep_d;
  logic [10:0] phase2_q, phase2_d;
  logic [11:0] phase4_q, phase4_d;
  rgb_t        last_colour_q;
  logic        last_valid_q;

  // result register
  logic out_valid_q;
  rgb_t led_q;

  logic       in_accept, advance;
  logic       do_eval, emit;
  logic [2:0] eval_mode;
  logic       show_layer_flash;
  logic [7:0] dim_level;
  rgb_t       dimmed, colour;

  // handshake: input register drains whenever the result slot is free
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign out_valid_o = out_valid_q;
  assign led_rgb_o   = led_q;

  // next state from the registered item
  always_comb begin
    base_mode_d    = base_mode_q;
    flash_voice_d  = flash_voice_q;
    flash_act_d    = flash_act_q;
    layer_flash_d  = layer_flash_q;
    flash_rem_d    = flash_rem_q;
    layer_colour_d = layer_colour_q;
    batt_low_d     = batt_low_q;
    wifi_sleep_d   = wifi_sleep_q;
    phase2_d       = phase2_q;
    phase4_d       = phase4_q;
    do_eval        = 1'b0;
    eval_mode      = base_mode_q;

    case (op_e'(op_q))
      OP_TICK: begin
        phase2_d = (phase2_q == PHASE_TWO_LAST) ? 11'd0 : phase2_q + 11'd1;
        phase4_d = (phase4_q == PHASE_FOUR_LAST) ? 12'd0 : phase4_q + 12'd1;
        if (flash_act_q) begin
          if (flash_rem_q == 8'd0) begin
            flash_act_d = 1'b0;
          end else begin
            flash_rem_d = flash_rem_q - 8'd1;
          end
        end
        do_eval = 1'b1;
        if (flash_act_d) begin
          eval_mode = flash_voice_q ? MODE_VOICE_KEY : MODE_HID_KEY;
        end
      end
      OP_SET_MODE: begin
        // key-press codes are not valid base modes: ignored
        if (ns_q != MODE_HID_KEY && ns_q != MODE_VOICE_KEY) begin
          flash_act_d = 1'b0;
          base_mode_d = ns_q;
          eval_mode   = ns_q;
          do_eval     = 1'b1;
        end
      end
      OP_KEY_FLASH: begin
        layer_flash_d = 1'b0;
        flash_voice_d = vk_q;
        flash_rem_d   = key_flash_ms_q;
        flash_act_d   = 1'b1;
      end
      OP_LAYER_COLOUR: begin
        layer_colour_d = (rgb_q == COLOUR_OFF) ? COLOUR_GREEN : rgb_q;
        layer_flash_d  = 1'b1;
        flash_rem_d    = layer_flash_ms_q;
        flash_act_d    = 1'b1;
      end
      OP_WIFI_SLEEP: begin
        if (wifi_sleep_q != fv_q) begin
          wifi_sleep_d = fv_q;
          do_eval      = 1'b1;
        end
      end
      OP_LOW_BATTERY: begin
        batt_low_d = fv_q;
      end
      default: begin
      end
    endcase
  end

  // one dimmer serves both layer flash (pulse level) and steady layer colour
  assign show_layer_flash = layer_flash_d && flash_act_d;
  assign dim_level        = show_layer_flash ? pulse_level_q : steady_level_q;

  slpg_dim u_dim (
    .colour_i (layer_colour_d),
    .level_i  (dim_level),
    .colour_o (dimmed)
  );

  // priority: layer flash, battery pulse, sleep red, mode colour
  always_comb begin
    if (show_layer_flash) begin
      colour = dimmed;
    end else if (batt_low_d && eval_mode == MODE_CONNECTED &&
                 (phase2_d < PULSE_ONE_END ||
                  (phase2_d >= PULSE_TWO_START && phase2_d < PULSE_TWO_END))) begin
      colour = COLOUR_WHITE_DIM;
    end else if (wifi_sleep_d) begin
      // full red scaled: red channel equals the level itself
      colour = {steady_level_q, 16'h0000};
    end else begin
      case (eval_mode)
        MODE_WAITING:   colour = (phase4_d < HEARTBEAT_ON) ? COLOUR_RED_DIM
                                                           : COLOUR_RED_FAINT;
        MODE_CONNECTED: colour = dimmed;
        MODE_MIC:       colour = COLOUR_BLUE_DIM;
        MODE_HID_KEY:   colour = COLOUR_YELLOW_DIM;
        MODE_VOICE_KEY: colour = COLOUR_RED_DIM;
        default:        colour = COLOUR_OFF;
      endcase
    end
  end

  // send only on change, or the very first colour
  assign emit = do_eval && (!last_valid_q || colour != last_colour_q);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steady_level_q   <= STEADY_LEVEL_RST;
      pulse_level_q    <= PULSE_LEVEL_RST;
      key_flash_ms_q   <= KEY_FLASH_MS_RST;
      layer_flash_ms_q <= LAYER_FLASH_MS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_STEADY_LEVEL:   steady_level_q   <= cfg_wdata_i;
        CFG_PULSE_LEVEL:    pulse_level_q    <= cfg_wdata_i;
        CFG_KEY_FLASH_MS:   key_flash_ms_q   <= cfg_wdata_i;
        CFG_LAYER_FLASH_MS: layer_flash_ms_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= operation_i;
      ns_q  <= new_state_i;
      vk_q  <= voice_key_i;
      rgb_q <= layer_rgb_i;
      fv_q  <= flag_value_i;
    end
  end

  // block state, updated as the item leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_mode_q    <= MODE_WAITING;
      flash_voice_q  <= 1'b0;
      flash_act_q    <= 1'b0;
      layer_flash_q  <= 1'b0;
      flash_rem_q    <= 8'd0;
      layer_colour_q <= COLOUR_GREEN;
      batt_low_q     <= 1'b0;
      wifi_sleep_q   <= 1'b0;
      phase2_q       <= 11'd0;
      phase4_q       <= 12'd0;
      last_colour_q  <= COLOUR_OFF;
      last_valid_q   <= 1'b0;
    end else if (advance) begin
      base_mode_q    <= base_mode_d;
      flash_voice_q  <= flash_voice_d;
      flash_act_q    <= flash_act_d;
      layer_flash_q  <= layer_flash_d;
      flash_rem_q    <= flash_rem_d;
      layer_colour_q <= layer_colour_d;
      batt_low_q     <= batt_low_d;
      wifi_sleep_q   <= wifi_sleep_d;
      phase2_q       <= phase2_d;
      phase4_q       <= phase4_d;
      if (emit) begin
        last_colour_q <= colour;
        last_valid_q  <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      led_q <= colour;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/slpg_checker.sv =====
// ----------------------------------------------------------------------------
// Status LED pattern generator checker
// Port-level checks, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "status_led_pattern_generator_unit_assert.svh"

module slpg_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [23:0] led_rgb_o
);

  logic        out_accept;
  logic        seen_q;
  logic [23:0] last_q;

  assign out_accept = out_valid_o && !out_stall_i;

  // last delivered colour
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      last_q <= '0;
    end else if (out_accept) begin
      seen_q <= 1'b1;
      last_q <= led_rgb_o;
    end
  end

  // stalled result holds
  `SLPG_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(led_rgb_o))

  // colours are only sent on change
  `SLPG_ASSERT(a_out_changes, out_accept && seen_q |-> led_rgb_o != last_q)

  // an empty result slot never stalls the input
  `SLPG_ASSERT(a_no_stall_empty, !out_valid_o |-> !in_stall_o)

  // nothing is offered while in reset
  `SLPG_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o)

endmodule

bind status_led_pattern_generator_unit slpg_checker u_slpg_checker (.*);

`default_nettype wire

// ===== test/tb_status_led_pattern_generator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Status LED pattern generator testbench
// Drives ticks and events into the colour sequencer, predicts each colour
// change, and checks every emitted colour in order against the prediction.
// ----------------------------------------------------------------------------

module tb_status_led_pattern_generator_unit;
  import slpg_pkg::*;

  // operation codes the block must ignore
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  // mode codes that turn the LED off
  localparam logic [2:0] MODE_OFF_FIRST = 3'd5;
  localparam logic [2:0] MODE_OFF_LAST  = 3'd7;
  localparam rgb_t RED_FULL = 24'hFF0000;

  localparam int unsigned SEGMENTS      = 6;
  localparam int unsigned ITEMS_PER_SEG = 150;
  // no handshake for this long means the block is hung
  localparam int unsigned STUCK_LIMIT   = 1000;

  // --------------------------------------------------------------------------
  // Colour predictor and store of expected colours
  // --------------------------------------------------------------------------
  class led_colour_scoreboard;
    logic [7:0]  steady_lvl, pulse_lvl, key_len, layer_len;
    logic [2:0]  mode;
    bit          flash_voice, flash_on, layer_flash_on;
    logic [7:0]  flash_left;
    rgb_t        layer_rgb;
    bit          batt_low, asleep;
    int unsigned phase_two, phase_four;
    rgb_t        last_rgb;
    bit          last_ok;
    rgb_t        expected_q[$];
    int unsigned errors, items_noted, colours_checked;

    function new();
      steady_lvl = STEADY_LEVEL_RST;
      pulse_lvl  = PULSE_LEVEL_RST;
      key_len    = KEY_FLASH_MS_RST;
      layer_len  = LAYER_FLASH_MS_RST;
      mode = MODE_WAITING;
      flash_voice = 0;
      flash_on = 0;
      layer_flash_on = 0;
      flash_left = '0;
      layer_rgb = COLOUR_GREEN;
      batt_low = 0;
      asleep = 0;
      phase_two = 0;
      phase_four = 0;
      last_rgb = COLOUR_OFF;
      last_ok = 0;
      errors = 0;
      items_noted = 0;
      colours_checked = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [7:0] v);
      case (idx)
        CFG_STEADY_LEVEL:   steady_lvl = v;
        CFG_PULSE_LEVEL:    pulse_lvl  = v;
        CFG_KEY_FLASH_MS:   key_len    = v;
        CFG_LAYER_FLASH_MS: layer_len  = v;
        default: ;
      endcase
    endfunction

    // per-channel c*level/255, truncating
    function rgb_t dim(rgb_t c, logic [7:0] lvl);
      int unsigned r, g, b;
      r = c[23:16] * lvl / 255;
      g = c[15:8] * lvl / 255;
      b = c[7:0] * lvl / 255;
      return {r[7:0], g[7:0], b[7:0]};
    endfunction

    function rgb_t choose_colour(logic [2:0] m);
      if (layer_flash_on && flash_on) return dim(layer_rgb, pulse_lvl);
      if (batt_low && m == MODE_CONNECTED &&
          (phase_two < PULSE_ONE_END ||
           (phase_two >= PULSE_TWO_START && phase_two < PULSE_TWO_END)))
        return COLOUR_WHITE_DIM;
      if (asleep) return dim(RED_FULL, steady_lvl);
      case (m)
        MODE_WAITING:   return (phase_four < HEARTBEAT_ON) ? COLOUR_RED_DIM
                                                           : COLOUR_RED_FAINT;
        MODE_CONNECTED: return dim(layer_rgb, steady_lvl);
        MODE_MIC:       return COLOUR_BLUE_DIM;
        MODE_HID_KEY:   return COLOUR_YELLOW_DIM;
        MODE_VOICE_KEY: return COLOUR_RED_DIM;
        default:        return COLOUR_OFF;
      endcase
    endfunction

    // queue a colour only when it differs from the last one sent
    function void post_colour(logic [2:0] m);
      rgb_t c;
      c = choose_colour(m);
      if (last_ok && c == last_rgb) return;
      last_rgb = c;
      last_ok = 1;
      expected_q.push_back(c);
    endfunction

    function void note_item(logic [2:0] op, logic [2:0] st, logic vk, rgb_t rgb,
                            logic fv);
      items_noted++;
      case (op)
        OP_TICK: begin
          phase_two  = (phase_two == PHASE_TWO_LAST) ? 0 : phase_two + 1;
          phase_four = (phase_four == PHASE_FOUR_LAST) ? 0 : phase_four + 1;
          if (flash_on) begin
            if (flash_left == 0) flash_on = 0;
            else flash_left = flash_left - 1;
          end
          if (flash_on) post_colour(flash_voice ? MODE_VOICE_KEY : MODE_HID_KEY);
          else post_colour(mode);
        end
        OP_SET_MODE: begin
          if (st != MODE_HID_KEY && st != MODE_VOICE_KEY) begin
            flash_on = 0;
            mode = st;
            post_colour(mode);
          end
        end
        OP_KEY_FLASH: begin
          layer_flash_on = 0;
          flash_voice = vk;
          flash_left = key_len;
          flash_on = 1;
        end
        OP_LAYER_COLOUR: begin
          layer_rgb = (rgb == COLOUR_OFF) ? COLOUR_GREEN : rgb;
          layer_flash_on = 1;
          flash_left = layer_len;
          flash_on = 1;
        end
        OP_WIFI_SLEEP: begin
          if (asleep != fv) begin
            asleep = fv;
            post_colour(mode);
          end
        end
        OP_LOW_BATTERY: batt_low = fv;
        default: ;
      endcase
    endfunction

    function void check_result(rgb_t got);
      rgb_t want;
      colours_checked++;
      if (expected_q.size() == 0) begin
        $display("%0t: led_rgb mismatch, expected none, got %06h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        $display("%0t: led_rgb mismatch, expected %06h, got %06h", $time, want, got);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic       clk_i;
  logic       rst_ni        = 1'b1;
  logic       in_valid_i    = 1'b0;
  logic       in_stall_o;
  logic [2:0] operation_i   = '0;
  logic [2:0] new_state_i   = '0;
  logic       voice_key_i   = 1'b0;
  rgb_t       layer_rgb_i   = '0;
  logic       flag_value_i  = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i   = 1'b0;
  rgb_t       led_rgb_o;
  logic       cfg_we_i      = 1'b0;
  logic [1:0] cfg_index_i   = '0;
  logic [7:0] cfg_wdata_i   = '0;

  // percent of cycles each side holds back
  int unsigned send_idle_pct = 19;
  int unsigned rcv_idle_pct  = 48;
  int unsigned stuck_cycles  = 0;

  led_colour_scoreboard sb = new();

  status_led_pattern_generator_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .new_state_i  (new_state_i),
    .voice_key_i  (voice_key_i),
    .layer_rgb_i  (layer_rgb_i),
    .flag_value_i (flag_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .led_rgb_o    (led_rgb_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // receiver: random stall, changed only on the falling edge
  initial begin
    forever begin
      @(negedge clk_i);
      out_stall_i <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // Both channels are sampled on the rising edge. An accepted item is fed to
  // the predictor right away; the colour it causes shows up only after the input
  // and result registers, so the expectation is always queued first.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.note_item(operation_i, new_state_i, voice_key_i, layer_rgb_i, flag_value_i);
      if (out_valid_o && !out_stall_i)
        sb.check_result(led_rgb_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, giving up", $time, stuck_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks; all start and end just after a falling edge
  // --------------------------------------------------------------------------
  task automatic send_item(logic [2:0] op, logic [2:0] st, logic vk, rgb_t rgb,
                           logic fv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    new_state_i  <= st;
    voice_key_i  <= vk;
    layer_rgb_i  <= rgb;
    flag_value_i <= fv;
    // payload holds until the edge that takes it
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Random item; returns 0 for items the block just drops (key codes as a
  // mode, spare operations) so they don't count toward the segment size.
  task automatic send_random(output bit useful);
    int unsigned pick, colour_pick;
    logic [2:0]  op, st;
    rgb_t        rgb;
    pick = $urandom_range(99);
    colour_pick = $urandom_range(9);
    if (pick < 58)      op = OP_TICK;
    else if (pick < 70) op = OP_SET_MODE;
    else if (pick < 78) op = OP_KEY_FLASH;
    else if (pick < 85) op = OP_LAYER_COLOUR;
    else if (pick < 91) op = OP_WIFI_SLEEP;
    else if (pick < 97) op = OP_LOW_BATTERY;
    else                op = pick[0] ? OP_SPARE_HI : OP_SPARE_LO;
    // lean on connected mode: it reaches the layer colour and battery pulse
    st = ($urandom_range(9) < 4) ? MODE_CONNECTED : 3'($urandom_range(7));
    if (colour_pick == 0)      rgb = COLOUR_OFF;
    else if (colour_pick == 1) rgb = 24'hFFFFFF;
    else                       rgb = 24'($urandom);
    useful = !(op == OP_SPARE_LO || op == OP_SPARE_HI ||
               (op == OP_SET_MODE && (st == MODE_HID_KEY || st == MODE_VOICE_KEY)));
    send_item(op, st, 1'($urandom_range(1)), rgb, 1'($urandom_range(1)));
  endtask

  // register writes with a quiet cycle between, so write enable drops each time
  task automatic write_reg(cfg_idx_e idx, logic [7:0] v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= v;
    sb.set_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // wait out all expected colours plus the pipeline depth, since the last
  // items may still be in flight without causing a colour
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    bit          useful;
    int unsigned counted;
    logic [7:0]  steady, pulse, key_ms, layer_ms;

    // falling reset edge at time zero so the block's registers clear at once
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, reset register values. Walks every operation, the
    // ignored codes, the forced first colour, the battery pulse, sleep red,
    // flag repeats, a sleep change mid-flash and both layer colour extremes.
    send_item(OP_TICK, MODE_WAITING, 1'b0, COLOUR_OFF, 1'b0);
    send_item(OP_SET_MODE, MODE_HID_KEY, 1'b1, 24'hFFFFFF, 1'b1);
    send_item(OP_SET_MODE, MODE_VOICE_KEY, 1'b0, COLOUR_OFF, 1'b0);
    send_item(OP_SPARE_LO, MODE_OFF_LAST, 1'b1, 24'hFFFFFF, 1'b1);
    send_item(OP_SPARE_HI, MODE_MIC, 1'b0, COLOUR_OFF, 1'b0);
    send_item(OP_SET_MODE, MODE_MIC, 1'b0, COLOUR_OFF, 1'b0);
    send_item(OP_SET_MODE, MODE_OFF_FIRST, 1'b0, COLOUR_OFF, 1'b0);
    send_item(OP_SET_MODE, MODE_OFF_LAST, 1'b0, COLOUR_OFF, 1'b0);
    send_item(OP_SET_MODE, MODE_CONNECTED, 1'b0, COLOUR_OFF, 1'b0);
    send_item(OP_LOW_BATTERY, MODE_WAITING, 1'b0, COLOUR_OFF, 1'b1);
    send_item(OP_TICK, MODE_WAITING, 1'b0, COLOUR_OFF, 1'b0);
    send_item(OP_WIFI_SLEEP, MODE_WAITING, 1'b0, COLOUR_OFF, 1'b1);
    send_item(OP_WIFI_SLEEP, MODE_WAITING, 1'b0, COLOUR_OFF, 1'b1);
    send_item(OP_LOW_BATTERY, MODE_WAITING, 1'b0, COLOUR_OFF, 1'b0);
    send_item(OP_TICK, MODE_WAITING, 1'b0, COLOUR_OFF, 1'b0);
    send_item(OP_KEY_FLASH, MODE_WAITING, 1'b1, COLOUR_OFF, 1'b0);
    send_item(OP_TICK, MODE_WAITING, 1'b0, COLOUR_OFF, 1'b0);
    send_item(OP_WIFI_SLEEP, MODE_WAITING, 1'b0, COLOUR_OFF, 1'b0);
    send_item(OP_TICK, MODE_WAITING, 1'b0, COLOUR_OFF, 1'b0);
    send_item(OP_LAYER_COLOUR, MODE_WAITING, 1'b0, COLOUR_OFF, 1'b0);
    send_item(OP_TICK, MODE_WAITING, 1'b0, COLOUR_OFF, 1'b0);
    send_item(OP_LAYER_COLOUR, MODE_WAITING, 1'b0, 24'hFFFFFF, 1'b0);
    send_item(OP_TICK, MODE_WAITING, 1'b0, COLOUR_OFF, 1'b0);
    send_item(OP_KEY_FLASH, MODE_WAITING, 1'b0, COLOUR_OFF, 1'b0);
    send_item(OP_TICK, MODE_WAITING, 1'b0, COLOUR_OFF, 1'b0);
    send_item(OP_SET_MODE, MODE_WAITING, 1'b0, COLOUR_OFF, 1'b0);

    // Random part in segments. Each pair of segments shares a flow-control
    // mix: sender-light, then receiver-light, then flat out. The first three
    // register settings hit the extremes, including a zero flash length that
    // must never show; the rest are random with short flashes so that flash
    // start and end happen often.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain_pipeline();
      case (seg)
        0: begin steady = 8'd255; pulse = 8'd0;   key_ms = 8'd1;   layer_ms = 8'd255; end
        1: begin steady = 8'd0;   pulse = 8'd255; key_ms = 8'd255; layer_ms = 8'd1;   end
        2: begin steady = 8'd6;   pulse = 8'd12;  key_ms = 8'd0;   layer_ms = 8'd3;   end
        default: begin
          steady   = 8'($urandom_range(255));
          pulse    = 8'($urandom_range(255));
          key_ms   = 8'($urandom_range(40, 1));
          layer_ms = 8'($urandom_range(60, 1));
        end
      endcase
      write_reg(CFG_STEADY_LEVEL, steady);
      write_reg(CFG_PULSE_LEVEL, pulse);
      write_reg(CFG_KEY_FLASH_MS, key_ms);
      write_reg(CFG_LAYER_FLASH_MS, layer_ms);
      case (seg / 2)
        0:       begin send_idle_pct = 19; rcv_idle_pct = 48; end
        1:       begin send_idle_pct = 48; rcv_idle_pct = 19; end
        default: begin send_idle_pct = 0;  rcv_idle_pct = 0;  end
      endcase
      counted = 0;
      while (counted < ITEMS_PER_SEG) begin
        send_random(useful);
        if (useful) counted++;
      end
    end

    // drain, then give a late or extra colour time to show up
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Ran %0d items over %0d register settings and three flow-control mixes.",
             sb.items_noted, SEGMENTS + 1);
    $display("Checked %0d colour changes, %0d mismatches.", sb.colours_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/slpg_pkg.sv
hw/rtl/slpg_dim.sv
hw/rtl/status_led_pattern_generator_unit.sv
hw/rtl/slpg_checker.sv
test/tb_status_led_pattern_generator_unit.sv
